### hw/rtl/phonetic_word_finder_macros.svh
// Assertion macros shared by the RTL of the phonetic word finder.
// Each macro expects clk_i and rst_ni in scope.
`ifndef PHONETIC_WORD_FINDER_MACROS_SVH
`define PHONETIC_WORD_FINDER_MACROS_SVH

// Same-cycle implication, checked only outside reset.
`define PWF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("phonetic_word_finder: same-cycle assertion failed");

// Next-cycle implication, checked only outside reset.
`define PWF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("phonetic_word_finder: next-cycle assertion failed");

`endif

### hw/rtl/pwf_pkg.sv
package pwf_pkg;

  localparam int unsigned MaxKeyword = 8;
  localparam int unsigned CharW      = 8;
  localparam int unsigned WordW      = MaxKeyword * CharW;
  localparam int unsigned KeyIdxW    = $clog2(MaxKeyword);
  localparam int unsigned CountW     = $clog2(MaxKeyword + 2);
  localparam int unsigned LengthW    = 4;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;

  // Distance between an upper-case and a lower-case letter.
  localparam logic [CharW:0] CaseGap = (CharW + 1)'(32);

  typedef enum logic [CfgIdxW-1:0] {
    RegKeywordChars  = 2'd0,
    RegKeywordLength = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    SndNone,
    SndD,
    SndU,
    SndV,
    SndC,
    SndG,
    SndI,
    SndS,
    SndB
  } snd_class_e;

  typedef struct packed {
    logic               found;
    logic [WordW-1:0]   matched_word;
    logic [LengthW-1:0] matched_length;
  } result_t;

  function automatic logic is_letter(input logic [CharW-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic snd_class_e sound_class(input logic [CharW-1:0] c);
    logic [CharW-1:0] lc;
    snd_class_e       cls;
    lc  = c | 8'h20;
    cls = SndNone;
    if (is_letter(c)) begin
      case (lc) inside
        8'h64, 8'h74:        cls = SndD;  // d t
        8'h75, 8'h6f:        cls = SndU;  // u o
        8'h76, 8'h77:        cls = SndV;  // v w
        8'h63, 8'h6b, 8'h71: cls = SndC;  // c k q
        8'h67, 8'h6a:        cls = SndG;  // g j
        8'h69, 8'h79:        cls = SndI;  // i y
        8'h73, 8'h7a:        cls = SndS;  // s z
        8'h62, 8'h66, 8'h70: cls = SndB;  // b f p
        default:             cls = SndNone;
      endcase
    end
    return cls;
  endfunction

  // True when a text letter counts as equal to the keyword byte.
  function automatic logic letter_ok(input logic [CharW-1:0] key, input logic [CharW-1:0] txt);
    snd_class_e     kc;
    logic [CharW:0] ky9;
    logic [CharW:0] tx9;
    logic           ok;
    kc  = sound_class(key);
    ky9 = {1'b0, key};
    tx9 = {1'b0, txt};
    if (kc != SndNone) begin
      ok = (sound_class(txt) == kc);
    end else if (key[CharW-1]) begin
      ok = 1'b0;
    end else begin
      ok = (tx9 == ky9) || (tx9 == ky9 + CaseGap) || (tx9 + CaseGap == ky9);
    end
    return ok;
  endfunction

endpackage

### hw/rtl/pwf_if.sv
// Text input channel.
interface pwf_in_if import pwf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] text_char;
  logic             end_of_text;

  modport source (output valid, output text_char, output end_of_text, input ready);
  modport sink   (input valid, input text_char, input end_of_text, output ready);
endinterface

// Result output channel.
interface pwf_out_if import pwf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [WordW-1:0]   matched_word;
  logic [LengthW-1:0] matched_length;

  modport source (output valid, output found, output matched_word, output matched_length,
                  input ready);
  modport sink   (input valid, input found, input matched_word, input matched_length,
                  output ready);
endinterface

// Configuration write channel.
interface pwf_cfg_if import pwf_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hw/rtl/phonetic_word_finder.sv
// A result beat is registered from the text beat that ends the word or text.
// One text beat per cycle while text is not held off; the class compare is combinational.
// A two-entry output stage (result register plus skid register) keeps text flowing while a
// result waits; text is held off only when both entries are full.
// Reset (asynchronous, active low) clears the word state, the match flag and both output
// entries, and sets the keyword to zero and the keyword length to one.
`include "phonetic_word_finder_macros.svh"

module phonetic_word_finder import pwf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  pwf_in_if.sink    text_i,
  pwf_out_if.source result_o,
  pwf_cfg_if.sink   cfg_i
);

  // Configuration registers. Writes are always taken, as ready is tied high.
  logic [WordW-1:0]   keyword_chars_q;
  logic [LengthW-1:0] keyword_length_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keyword_chars_q  <= '0;
      keyword_length_q <= LengthW'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegKeywordChars:  keyword_chars_q  <= cfg_i.data[WordW-1:0];
        RegKeywordLength: keyword_length_q <= cfg_i.data[LengthW-1:0];
        default: ;
      endcase
    end
  end

  // Word state. The letter store has no reset: only entries below the letter count are read,
  // and those have always been written by the current word.
  logic [CharW-1:0]  word_q [MaxKeyword];
  logic [CountW-1:0] count_q, count_d;
  logic              mismatch_q, mismatch_d;
  logic              done_q, done_d;

  logic              in_fire;
  logic              is_let;
  logic              word_we;
  logic [CharW-1:0]  key_byte;
  logic [CountW-1:0] cnt_after;
  logic              mis_after;
  logic              len_ok;
  logic              match;
  logic              res_valid;
  result_t           res;

  assign in_fire  = text_i.valid && text_i.ready;
  assign is_let   = is_letter(text_i.text_char);
  assign key_byte = keyword_chars_q[CharW*count_q[KeyIdxW-1:0] +: CharW];
  assign len_ok   = (keyword_length_q != '0) && (keyword_length_q <= LengthW'(MaxKeyword));

  always_comb begin
    word_we   = 1'b0;
    cnt_after = count_q;
    mis_after = mismatch_q;

    // Letter step: compare against the keyword byte at this position, or saturate the count
    // once the word has outgrown the largest keyword.
    if (is_let) begin
      if (count_q < CountW'(MaxKeyword)) begin
        word_we   = 1'b1;
        cnt_after = count_q + CountW'(1);
        if (!letter_ok(key_byte, text_i.text_char)) begin
          mis_after = 1'b1;
        end
      end else begin
        cnt_after = CountW'(MaxKeyword + 1);
        mis_after = 1'b1;
      end
    end

    match = len_ok && !mis_after && (cnt_after == CountW'(keyword_length_q));

    // Packed word: the letter of this beat has not reached the store yet, so it is
    // taken straight from the input.
    res.found          = match;
    res.matched_length = match ? keyword_length_q : '0;
    res.matched_word   = '0;
    for (int i = 0; i < MaxKeyword; i++) begin
      if (match && (CountW'(i) < CountW'(keyword_length_q))) begin
        if (is_let && (count_q == CountW'(i))) begin
          res.matched_word[CharW*i +: CharW] = text_i.text_char;
        end else begin
          res.matched_word[CharW*i +: CharW] = word_q[i];
        end
      end
    end

    count_d    = count_q;
    mismatch_d = mismatch_q;
    done_d     = done_q;
    res_valid  = 1'b0;

    if (in_fire) begin
      if (done_q) begin
        // After a match the text is skipped until its last beat, which returns to idle.
        word_we = 1'b0;
        if (text_i.end_of_text) begin
          done_d     = 1'b0;
          count_d    = '0;
          mismatch_d = 1'b0;
        end
      end else if (!is_let || text_i.end_of_text) begin
        // The word ends here. A match is reported; the end of the text always gives one
        // result, found or not.
        res_valid  = match || text_i.end_of_text;
        done_d     = match && !text_i.end_of_text;
        count_d    = '0;
        mismatch_d = 1'b0;
      end else begin
        count_d    = cnt_after;
        mismatch_d = mis_after;
      end
    end else begin
      word_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_q[count_q[KeyIdxW-1:0]] <= text_i.text_char;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      mismatch_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      count_q    <= count_d;
      mismatch_q <= mismatch_d;
      done_q     <= done_d;
    end
  end

  // Output stage: the result register feeds the port, and the skid register catches a
  // result that arrives while the port is stalled. Text is held off only while the skid
  // register is occupied, so results never overtake one another.
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  logic    pop;

  assign pop = out_valid_q && result_o.ready;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (pop) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || pop) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign text_i.ready            = !skid_valid_q;
  assign result_o.valid          = out_valid_q;
  assign result_o.found          = out_q.found;
  assign result_o.matched_word   = out_q.matched_word;
  assign result_o.matched_length = out_q.matched_length;

  // The skid entry is only ever filled behind a waiting result.
  `PWF_ASSERT_IMPL(skid_behind_out, skid_valid_q, out_valid_q)
  // The letter count never passes its saturation value.
  `PWF_ASSERT_IMPL(count_in_range, 1'b1, count_q <= CountW'(MaxKeyword + 1))
  // While a match is already reported, text beats produce no further result.
  `PWF_ASSERT_IMPL(quiet_after_match, in_fire && done_q, !res_valid)
  // A stalled skid entry is handed on to the port once the port drains.
  `PWF_ASSERT_NEXT(skid_drains, skid_valid_q && result_o.ready, !skid_valid_q && out_valid_q)

endmodule

### bench/tb_phonetic_word_finder.sv
module tb_phonetic_word_finder;
  import pwf_pkg::*;

  // The register map has room for more indexes than it uses. A write to a spare
  // index must leave both keyword registers alone.
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;

  // Run length and back-pressure settings.
  localparam int unsigned CycleLimit   = 400000;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned RandomBeats  = 1700;
  localparam int unsigned HoldAt       = 500;
  localparam int unsigned HoldCycles   = 2000;
  localparam int unsigned HoldTexts    = 3;

  // One text beat waiting to be offered. A beat marked drain_first is held back
  // until every report predicted so far has been received.
  typedef struct {
    logic [CharW-1:0] ch;
    logic             eot;
    logic             drain_first;
  } text_beat_t;

  logic clk_i;
  logic rst_ni = 1'b1;

  pwf_in_if  text_if ();
  pwf_out_if result_if ();
  pwf_cfg_if cfg_if ();

  phonetic_word_finder dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .text_i   (text_if),
    .result_o (result_if),
    .cfg_i    (cfg_if)
  );

  text_beat_t  pending_beats[$];
  result_t     predicted_reports[$];

  // Mirror of the configuration and of the search state, kept by the predictor.
  logic [WordW-1:0]   kw_chars = '0;
  logic [LengthW-1:0] kw_len   = LengthW'(1);
  logic [CharW-1:0]   word_buf [MaxKeyword];
  logic [LengthW-1:0] word_len      = '0;
  logic               word_bad      = 1'b0;
  logic               match_pending = 1'b0;

  int unsigned errors         = 0;
  int unsigned beats_accepted = 0;
  int unsigned random_beats   = 0;
  int unsigned cycle_count    = 0;
  int unsigned hold_left;
  logic        hold_done;
  int unsigned src_gap;
  int unsigned sink_wait;
  logic        steady_phase = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic logic is_alpha(input logic [CharW-1:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  // Every letter that shares a sound class is mapped to one lower-case letter of
  // that class; letters outside any class, and all non-letters, map to zero.
  function automatic logic [CharW-1:0] sound_group(input logic [CharW-1:0] c);
    logic [CharW-1:0] grp;
    grp = 8'h00;
    if (is_alpha(c)) begin
      case (c | 8'h20)
        "d", "t":      grp = "d";
        "u", "o":      grp = "u";
        "v", "w":      grp = "v";
        "c", "k", "q": grp = "c";
        "g", "j":      grp = "g";
        "i", "y":      grp = "i";
        "s", "z":      grp = "s";
        "b", "f", "p": grp = "b";
        default:       grp = 8'h00;
      endcase
    end
    return grp;
  endfunction

  // A keyword letter with a sound class accepts any letter of that class. Any
  // other keyword byte below 128 accepts itself and the byte a case step away,
  // whether that keyword byte is a letter or not. Bytes from 128 up accept nothing.
  function automatic logic letters_agree(input logic [CharW-1:0] key,
                                         input logic [CharW-1:0] txt);
    logic [CharW-1:0] grp;
    logic [CharW:0]   k9;
    logic [CharW:0]   t9;
    grp = sound_group(key);
    k9  = {1'b0, key};
    t9  = {1'b0, txt};
    if (grp != 8'h00) begin
      return sound_group(txt) == grp;
    end
    if (key[CharW-1]) begin
      return 1'b0;
    end
    return (t9 == k9) || (t9 == k9 + CaseGap) || (t9 + CaseGap == k9);
  endfunction

  // Advances the search by one accepted text beat and queues the report that the
  // beat should cause, if any.
  function automatic void scan_text_beat(input logic [CharW-1:0] c, input logic last);
    result_t rep;
    logic    reported;
    int      i;
    reported = 1'b0;
    rep      = '0;

    // Once a word has been reported the rest of the text is skipped silently; the
    // closing beat only clears the state.
    if (match_pending) begin
      if (last) begin
        match_pending = 1'b0;
        word_len      = '0;
        word_bad      = 1'b0;
      end
      return;
    end

    if (is_alpha(c)) begin
      if (word_len < MaxKeyword) begin
        word_buf[word_len] = c;
        if (!letters_agree(kw_chars[CharW*word_len +: CharW], c)) begin
          word_bad = 1'b1;
        end
        word_len = word_len + 1'b1;
      end else begin
        // Too long for any keyword: the count sticks one above the maximum.
        word_len = LengthW'(MaxKeyword + 1);
        word_bad = 1'b1;
      end
    end

    // A non-letter ends the word, and so does a letter that closes the text.
    if (!is_alpha(c) || last) begin
      if ((kw_len != 0) && (kw_len <= MaxKeyword) && (word_len == kw_len) && !word_bad) begin
        rep.found = 1'b1;
        for (i = 0; i < int'(word_len); i++) begin
          rep.matched_word[CharW*i +: CharW] = word_buf[i];
        end
        rep.matched_length = word_len;
        predicted_reports.push_back(rep);
        reported      = 1'b1;
        match_pending = !last;
      end
      word_len = '0;
      word_bad = 1'b0;
    end

    // A text that closes without a match still gets one report, with found clear.
    if (last && !reported) begin
      predicted_reports.push_back('0);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Text driver: offers the queued beats, drawing a random gap after each accepted
  // one (none in a steady phase), and feeds every accepted beat to the predictor.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : text_driver
    text_beat_t  nxt;
    logic        offer;
    int unsigned gap_n;
    if (!rst_ni) begin
      text_if.valid       <= 1'b0;
      text_if.text_char   <= '0;
      text_if.end_of_text <= 1'b0;
      src_gap             <= 0;
    end else begin
      offer = text_if.valid;
      gap_n = src_gap;
      if (text_if.valid && text_if.ready) begin
        scan_text_beat(text_if.text_char, text_if.end_of_text);
        beats_accepted = beats_accepted + 1;
        offer = 1'b0;
        gap_n = steady_phase ? 0 : $urandom_range(0, 6);
      end
      if (!offer) begin
        if (gap_n != 0) begin
          gap_n = gap_n - 1;
        end else if ((pending_beats.size() != 0) &&
                     !(pending_beats[0].drain_first && (predicted_reports.size() != 0))) begin
          nxt = pending_beats.pop_front();
          text_if.text_char   <= nxt.ch;
          text_if.end_of_text <= nxt.eot;
          offer = 1'b1;
        end
      end
      text_if.valid <= offer;
      src_gap       <= gap_n;
    end
  end

  // Number of whole texts the sender can still offer without pausing for the
  // results to drain. Each of them ends in exactly one report.
  function automatic int unsigned texts_ahead();
    int unsigned n;
    int          i;
    n = 0;
    for (i = 0; i < pending_beats.size(); i++) begin
      if (pending_beats[i].drain_first) begin
        break;
      end
      if (pending_beats[i].eot) begin
        n = n + 1;
      end
    end
    return n;
  endfunction

  // ---------------------------------------------------------------------------
  // Long hold-off on the result side. Once enough text has gone in, and at a
  // point where the sender still has several texts to offer, the receiver refuses
  // results for a long stretch so that both output entries fill and the block has
  // to stall its text input.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && (beats_accepted >= HoldAt) && (texts_ahead() >= HoldTexts)) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: checks each accepted report against the oldest prediction,
  // then draws how many cycles to stall before taking the next one.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    result_t     exp;
    int unsigned wait_n;
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      sink_wait       <= 0;
    end else begin
      wait_n = sink_wait;
      if (result_if.valid && result_if.ready) begin
        if (predicted_reports.size() == 0) begin
          $error("report beat with no report predicted: found %0d, word %h, length %0d",
                 result_if.found, result_if.matched_word, result_if.matched_length);
          errors = errors + 1;
        end else begin
          exp = predicted_reports.pop_front();
          if (result_if.found !== exp.found) begin
            $error("found: expected %0d, got %0d", exp.found, result_if.found);
            errors = errors + 1;
          end
          if (result_if.matched_word !== exp.matched_word) begin
            $error("matched_word: expected %h, got %h", exp.matched_word,
                   result_if.matched_word);
            errors = errors + 1;
          end
          if (result_if.matched_length !== exp.matched_length) begin
            $error("matched_length: expected %0d, got %0d", exp.matched_length,
                   result_if.matched_length);
            errors = errors + 1;
          end
        end
        wait_n = steady_phase ? 0 : $urandom_range(0, 6);
      end else if (wait_n != 0) begin
        wait_n = wait_n - 1;
      end
      sink_wait       <= wait_n;
      result_if.ready <= (wait_n == 0) && (hold_left == 0);
    end
  end

  // A run that stops making progress is cut off here.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [CharW-1:0] random_letter();
    return CharW'($urandom_range(0, 25)) + ($urandom_range(0, 1) ? "a" : "A");
  endfunction

  // Any byte that is not a letter, so that it closes the current word.
  function automatic logic [CharW-1:0] random_break();
    logic [CharW-1:0] c;
    do begin
      c = CharW'($urandom_range(0, 255));
    end while (is_alpha(c));
    return c;
  endfunction

  // Picks a letter that the given keyword byte accepts. Where none exists, as for
  // keyword bytes from 128 up, a random letter is used instead.
  function automatic logic [CharW-1:0] sound_alike(input logic [CharW-1:0] key);
    logic [CharW-1:0] c;
    int               tries;
    c = random_letter();
    for (tries = 0; tries < 200; tries++) begin
      c = random_letter();
      if (letters_agree(key, c)) begin
        return c;
      end
    end
    return c;
  endfunction

  function automatic logic [WordW-1:0] pack_word(input string s);
    logic [WordW-1:0] w;
    int               i;
    w = '0;
    for (i = 0; i < s.len(); i++) begin
      w[CharW*i +: CharW] = s[i];
    end
    return w;
  endfunction

  function automatic void queue_beat(input logic [CharW-1:0] c, input logic eot,
                                     input logic drain);
    text_beat_t b;
    b.ch          = c;
    b.eot         = eot;
    b.drain_first = drain;
    pending_beats.push_back(b);
  endfunction

  function automatic void queue_string(input string s, input logic eot_on_last);
    int i;
    for (i = 0; i < s.len(); i++) begin
      queue_beat(s[i], eot_on_last && (i == s.len() - 1), 1'b0);
    end
  endfunction

  // Called just after a rising edge. The write is held until the block takes it,
  // and the mirror is updated on the same edge.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == RegKeywordChars) begin
      kw_chars = val;
    end else if (idx == RegKeywordLength) begin
      kw_len = val[LengthW-1:0];
    end
    @(posedge clk_i);
  endtask

  // Waits until every queued beat has been taken and every predicted report has
  // arrived, then lets the block settle for SettleCycles, since a beat skipped after
  // a match gives no report to wait for.
  task automatic settle();
    do @(posedge clk_i);
    while ((pending_beats.size() != 0) || text_if.valid || (predicted_reports.size() != 0));
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Builds one random text of a few words. About half the words are sound-alikes of the
  // keyword, some slightly spoilt; the rest are random letter runs, overlong ones
  // among them, and raw bytes of any value.
  task automatic queue_random_text(input logic drain);
    logic [CharW-1:0] body[$];
    int               words;
    int               w;
    int               k;
    int               len;
    int               pos;
    int               kind;
    int               tweak;
    words = $urandom_range(1, 6);
    for (w = 0; w < words; w++) begin
      if (w > 0) begin
        body.push_back(random_break());
      end
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        len = ((kw_len >= 1) && (kw_len <= MaxKeyword)) ? int'(kw_len) : $urandom_range(1, 8);
        for (k = 0; k < len; k++) begin
          body.push_back(sound_alike(kw_chars[CharW*k +: CharW]));
        end
        tweak = $urandom_range(0, 5);
        if (tweak == 0) begin
          body[body.size() - 1 - $urandom_range(0, len - 1)] = random_letter();
        end else if (tweak == 1) begin
          body.push_back(random_letter());
        end else if ((tweak == 2) && (len > 1)) begin
          void'(body.pop_back());
        end
      end else if (kind <= 7) begin
        len = $urandom_range(1, 11);
        for (k = 0; k < len; k++) begin
          body.push_back(random_letter());
        end
      end else begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) begin
          body.push_back(CharW'($urandom_range(0, 255)));
        end
      end
    end
    // The text closes either on its last letter or on one extra byte of any value.
    if (!(is_alpha(body[body.size() - 1]) && $urandom_range(0, 1))) begin
      body.push_back(CharW'($urandom_range(0, 255)));
    end
    for (pos = 0; pos < body.size(); pos++) begin
      queue_beat(body[pos], pos == body.size() - 1, drain && (pos == 0));
    end
    random_beats = random_beats + body.size();
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [CfgDataW-1:0] chars;
    logic [CfgDataW-1:0] len_word;
    logic [LengthW-1:0]  len;
    int                  texts;
    int                  t;
    int                  k;
    logic                first_phase;

    cfg_if.valid <= 1'b0;
    cfg_if.index <= RegKeywordChars;
    cfg_if.data  <= '0;
    rst_ni       <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Three-letter keyword. The first text matches on its closing letter, so the
    // found report is the only one. The second has a short word, then a match on
    // a comma, after which the closing byte is skipped without a report.
    write_reg(RegKeywordChars, pack_word("Cat"));
    write_reg(RegKeywordLength, CfgDataW'(3));
    queue_string("qAT", 1'b1);
    queue_string("ca kad,x", 1'b1);
    settle();

    // Longest keyword, against a nine-letter word that saturates the count.
    write_reg(RegKeywordChars, pack_word("abcdefgh"));
    write_reg(RegKeywordLength, CfgDataW'(MaxKeyword));
    queue_string("ABCDEFGHX.", 1'b1);
    settle();

    // A keyword byte that is a digit accepts the letter a case step above it. The
    // text opens with the two extreme byte values as separators.
    write_reg(RegKeywordChars, CfgDataW'(8'h31));
    write_reg(RegKeywordLength, CfgDataW'(1));
    queue_beat(8'hff, 1'b0, 1'b0);
    queue_beat(8'h00, 1'b0, 1'b0);
    queue_string("Q", 1'b1);
    settle();

    // A keyword byte from 128 up accepts nothing.
    write_reg(RegKeywordChars, CfgDataW'(8'hc1));
    queue_string("a", 1'b1);
    settle();

    // A keyword length of zero never matches.
    write_reg(RegKeywordChars, pack_word("a"));
    write_reg(RegKeywordLength, CfgDataW'(0));
    queue_string("a", 1'b1);
    settle();

    // Keyword changed in the middle of a word: the first letter was already judged
    // against the old keyword. A write to a spare index changes nothing.
    write_reg(RegKeywordChars, pack_word("ab"));
    write_reg(RegKeywordLength, CfgDataW'(2));
    queue_string("a", 1'b0);
    settle();
    write_reg(RegKeywordChars, pack_word("zb"));
    write_reg(RegSpare, '1);
    queue_string("b", 1'b1);
    settle();

    // Random phases, each with a fresh keyword and length, including lengths out
    // of range and keywords of non-letter bytes. Upper bits of the length word are
    // random, as only its low bits are kept.
    first_phase = 1'b1;
    while (random_beats < RandomBeats) begin
      case ($urandom_range(0, 9))
        0:       chars = '0;
        1:       chars = '1;
        2:       chars = {$urandom, $urandom};
        default: begin
          for (k = 0; k < MaxKeyword; k++) begin
            chars[CharW*k +: CharW] = random_letter();
          end
        end
      endcase
      case ($urandom_range(0, 19))
        0:       len = '0;
        1:       len = LengthW'($urandom_range(MaxKeyword + 1, 15));
        default: len = LengthW'($urandom_range(1, MaxKeyword));
      endcase
      len_word          = {$urandom, $urandom};
      len_word[LengthW-1:0] = len;
      write_reg(RegKeywordChars, chars);
      write_reg(RegKeywordLength, len_word);
      if ($urandom_range(0, 4) == 0) begin
        write_reg(RegSpare, {$urandom, $urandom});
      end
      steady_phase <= ($urandom_range(0, 3) == 0);
      texts = $urandom_range(3, 8);
      for (t = 0; t < texts; t++) begin
        queue_random_text((first_phase && (t == 1)) || ($urandom_range(0, 9) == 0));
      end
      first_phase = 1'b0;
      settle();
    end

    if (predicted_reports.size() != 0) begin
      $error("%0d predicted reports never arrived", predicted_reports.size());
      errors = errors + 1;
    end
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
